[hdl/pvc_pkg.sv]
// Shared types, register codes and reset constants for the PID velocity controller.
`default_nettype none

package pvc_pkg;

  // Default number of wheel channels
  localparam int unsigned PvcChannels = 6;

  // Payload widths
  localparam int unsigned ChanW  = 3;
  localparam int unsigned VelW   = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 16;
  localparam int unsigned PerW   = 20;
  localparam int unsigned DriveW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_LIMIT_HIGH    = 3'd3,
    REG_LIMIT_LOW     = 3'd4,
    REG_SAMPLE_PERIOD = 3'd5
  } pvc_reg_e;

  // Reset values of the configuration registers
  localparam logic signed [GainW-1:0] GainPRst   = 16'sd20480;  // 80.0 in Q8.8
  localparam logic signed [GainW-1:0] GainIRst   = 16'sd7680;   // 30.0 in Q8.8
  localparam logic signed [GainW-1:0] GainDRst   = 16'sd0;
  localparam logic signed [LimW-1:0]  LimHighRst = 16'sd100;
  localparam logic signed [LimW-1:0]  LimLowRst  = -16'sd100;
  localparam logic [PerW-1:0]         PeriodRst  = 20'd10000;   // microseconds

  // Live configuration
  typedef struct packed {
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic signed [LimW-1:0]  limit_high;
    logic signed [LimW-1:0]  limit_low;
    logic [PerW-1:0]         sample_period;
  } pvc_cfg_t;

  // Per-channel loop state
  typedef struct packed {
    logic signed [VelW-1:0] integ;      // Q16.16
    logic signed [VelW-1:0] prev_meas;  // Q16.16
    logic signed [VelW-1:0] held;       // Q16.16
    logic [TimeW-1:0]       last_time;  // microseconds
  } pvc_state_t;

endpackage

`default_nettype wire

[hdl/pvc_cfg_regs.sv]
// Configuration register file of the PID velocity controller.
`default_nettype none

module pvc_cfg_regs import pvc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output pvc_cfg_t                 cfg_o
);

  pvc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pvc_reg_e'(cfg_index_i))
        REG_GAIN_P:        cfg_d.gain_p        = $signed(cfg_data_i[GainW-1:0]);
        REG_GAIN_I:        cfg_d.gain_i        = $signed(cfg_data_i[GainW-1:0]);
        REG_GAIN_D:        cfg_d.gain_d        = $signed(cfg_data_i[GainW-1:0]);
        REG_LIMIT_HIGH:    cfg_d.limit_high    = $signed(cfg_data_i[LimW-1:0]);
        REG_LIMIT_LOW:     cfg_d.limit_low     = $signed(cfg_data_i[LimW-1:0]);
        REG_SAMPLE_PERIOD: cfg_d.sample_period = cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p        <= GainPRst;
      cfg_q.gain_i        <= GainIRst;
      cfg_q.gain_d        <= GainDRst;
      cfg_q.limit_high    <= LimHighRst;
      cfg_q.limit_low     <= LimLowRst;
      cfg_q.sample_period <= PeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[hdl/pvc_pid_math.sv]
// One PID step: elapsed-time check, clamped integral, output clamp and truncation.
`default_nettype none

module pvc_pid_math import pvc_pkg::*; (
  input  wire pvc_cfg_t                cfg_i,
  input  wire logic                    in_range_i,
  input  wire logic signed [VelW-1:0]  meas_i,
  input  wire logic signed [VelW-1:0]  tgt_i,
  input  wire logic [TimeW-1:0]        now_i,
  input  wire pvc_state_t              state_i,
  output pvc_state_t                   state_o,
  output logic                         upd_o,
  output logic signed [DriveW-1:0]     drive_o
);

  logic [TimeW-1:0]        elapsed;
  logic signed [32:0]      err;
  logic signed [32:0]      dmeas;
  logic signed [48:0]      prod_i;
  logic signed [40:0]      istep;
  logic signed [41:0]      acc_raw;
  logic signed [31:0]      int_hi, int_lo;
  logic signed [31:0]      acc;
  logic signed [48:0]      prod_p, prod_d;
  logic signed [50:0]      sum_raw;
  logic signed [39:0]      out_hi, out_lo;
  logic signed [39:0]      sum_c;
  logic signed [39:0]      sum_adj;
  logic signed [31:0]      held_new;
  logic signed [31:0]      held_sel;
  logic signed [31:0]      held_adj;

  // Sample period gate on the wrapping timestamp
  assign elapsed = now_i - state_i.last_time;
  assign upd_o   = in_range_i && (elapsed >= TimeW'(cfg_i.sample_period));

  // Error and measurement step, one bit wider to stay exact
  assign err   = 33'(tgt_i) - 33'(meas_i);
  assign dmeas = 33'(meas_i) - 33'(state_i.prev_meas);

  // Integral: Ki*err in Q24.24, floor to Q16.16, accumulate and clamp
  assign prod_i  = 49'(cfg_i.gain_i) * 49'(err);
  assign istep   = prod_i[48:8];
  assign acc_raw = 42'(state_i.integ) + 42'(istep);
  assign int_hi  = $signed({cfg_i.limit_high, 16'b0});
  assign int_lo  = $signed({cfg_i.limit_low, 16'b0});

  always_comb begin
    if (acc_raw > 42'(int_hi)) begin
      acc = int_hi;
    end else if (acc_raw < 42'(int_lo)) begin
      acc = int_lo;
    end else begin
      acc = acc_raw[31:0];
    end
  end

  // Output sum in Q24.24, derivative on measurement
  assign prod_p  = 49'(cfg_i.gain_p) * 49'(err);
  assign prod_d  = 49'(cfg_i.gain_d) * 49'(dmeas);
  assign sum_raw = 51'(prod_p) - 51'(prod_d) + 51'($signed({acc, 8'b0}));
  assign out_hi  = $signed({cfg_i.limit_high, 24'b0});
  assign out_lo  = $signed({cfg_i.limit_low, 24'b0});

  always_comb begin
    if (sum_raw > 51'(out_hi)) begin
      sum_c = out_hi;
    end else if (sum_raw < 51'(out_lo)) begin
      sum_c = out_lo;
    end else begin
      sum_c = sum_raw[39:0];
    end
  end

  // Truncate toward zero to Q16.16
  assign sum_adj  = sum_c + (sum_c[39] ? 40'sd255 : 40'sd0);
  assign held_new = sum_adj[39:8];

  // Next channel state
  always_comb begin
    state_o = state_i;
    if (upd_o) begin
      state_o.integ     = acc;
      state_o.prev_meas = meas_i;
      state_o.held      = held_new;
      state_o.last_time = now_i;
    end
  end

  // Drive command: held output truncated toward zero to an integer
  assign held_sel = upd_o ? held_new : state_i.held;
  assign held_adj = held_sel + (held_sel[31] ? 32'sd65535 : 32'sd0);
  assign drive_o  = in_range_i ? held_adj[31:16] : '0;

endmodule

`default_nettype wire

[hdl/pid_velocity_controller.sv]
// Top level of the multi-channel PID velocity controller.
// Flow: an item is held in the input register, then its result in the result
//   register once it is free. Throughput: one item per cycle unless out_ready_i
//   stalls the result register; the PID step is one pass of combinational
//   logic between input and result registers, so same-channel items may follow.
// Reset: configuration registers take their documented defaults, all channel state clears.
`default_nettype none

module pid_velocity_controller import pvc_pkg::*; #(
  parameter int unsigned CHANNELS = PvcChannels
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration writes
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [CfgDataW-1:0]     cfg_data_i,
  // input items
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [ChanW-1:0]        channel_i,
  input  wire logic signed [VelW-1:0]  measured_velocity_i,
  input  wire logic signed [VelW-1:0]  target_velocity_i,
  input  wire logic [TimeW-1:0]        now_time_i,
  // result items
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [ChanW-1:0]             out_channel_o,
  output logic signed [DriveW-1:0]     drive_command_o,
  output logic                         updated_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  pvc_cfg_t cfg;

  // Input register
  logic                   s1_valid_q;
  logic [ChanW-1:0]       s1_chan_q;
  logic signed [VelW-1:0] s1_meas_q;
  logic signed [VelW-1:0] s1_tgt_q;
  logic [TimeW-1:0]       s1_time_q;

  // Result register
  logic                     out_valid_q;
  logic [ChanW-1:0]         out_chan_q;
  logic signed [DriveW-1:0] out_drive_q;
  logic                     out_upd_q;

  // Channel state
  pvc_state_t state_q [CHANNELS];

  logic                     out_free;
  logic                     s1_move;
  logic                     in_fire;
  logic [ChanW+IdxW-1:0]    chan_ext;
  logic [IdxW-1:0]          chan_idx;
  logic                     in_range;
  pvc_state_t               state_rd;
  pvc_state_t               state_wr;
  logic                     upd;
  logic signed [DriveW-1:0] drive;

  pvc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the input register drains into the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Channel decode
  assign chan_ext = {{IdxW{1'b0}}, s1_chan_q};
  assign chan_idx = chan_ext[IdxW-1:0];
  assign in_range = 32'(s1_chan_q) < 32'(CHANNELS);
  assign state_rd = state_q[chan_idx];

  pvc_pid_math u_math (
    .cfg_i      (cfg),
    .in_range_i (in_range),
    .meas_i     (s1_meas_q),
    .tgt_i      (s1_tgt_q),
    .now_i      (s1_time_q),
    .state_i    (state_rd),
    .state_o    (state_wr),
    .upd_o      (upd),
    .drive_o    (drive)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_chan_q <= channel_i;
      s1_meas_q <= measured_velocity_i;
      s1_tgt_q  <= target_velocity_i;
      s1_time_q <= now_time_i;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_chan_q  <= s1_chan_q;
      out_drive_q <= drive;
      out_upd_q   <= upd;
    end
  end

  // Channel state write-back, only on a real update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (s1_move && upd) begin
      state_q[chan_idx] <= state_wr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_channel_o   = out_chan_q;
  assign drive_command_o = out_drive_q;
  assign updated_o       = out_upd_q;

endmodule

`default_nettype wire
